[hw/rtl/mcdl_pkg.sv]
// ----------------------------------------------------------------------------
// mcdl_pkg
// Shared types and constants for the multi-channel debounce with lockout.
// ----------------------------------------------------------------------------
package mcdl_pkg;

  // widths of the request and result fields, counters, timer and configuration port
  localparam int unsigned FIELD_W    = 6;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TIMER_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // register reset values
  localparam logic [COUNT_W-1:0] DEBOUNCE_RST = 4'd4;
  localparam logic [TIMER_W-1:0] LOCKOUT_RST  = 8'd200;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LOCKOUT  = 2'd1
  } reg_idx_t;

  // settings seen by every channel
  typedef struct packed {
    logic [COUNT_W-1:0] debounce;
    logic [TIMER_W-1:0] lockout;
  } chan_cfg_t;

  // per-tick control into a channel
  typedef struct packed {
    logic step;    // a request is taken this cycle
    logic level;   // raw level, low is active
    logic absorb;  // pending marks fold into busy this tick
  } chan_ctl_t;

  // per-tick status out of a channel
  typedef struct packed {
    logic trig;     // debounce count reached this tick
    logic pend;     // pending after examination, before absorb
    logic pend_r;   // registered pending mark
  } chan_st_t;

endpackage

[hw/rtl/mcdl_in_if.sv]
// ----------------------------------------------------------------------------
// mcdl_in_if
// Request channel: one sampling tick with its clear controls.
// ----------------------------------------------------------------------------
interface mcdl_in_if;
  logic                                valid;
  logic                                ready;
  logic [mcdl_pkg::FIELD_W-1:0]        pin_levels;
  logic                                clear_busy;
  logic [mcdl_pkg::FIELD_W-1:0]        clear_latched;

  modport source (output valid, output pin_levels, output clear_busy,
                  output clear_latched, input ready);
  modport sink   (input valid, input pin_levels, input clear_busy,
                  input clear_latched, output ready);
endinterface

[hw/rtl/mcdl_out_if.sv]
// ----------------------------------------------------------------------------
// mcdl_out_if
// Result channel: flags after one sampling tick.
// ----------------------------------------------------------------------------
interface mcdl_out_if;
  logic                                valid;
  logic                                ready;
  logic                                busy_res;
  logic [mcdl_pkg::FIELD_W-1:0]        latched_events;
  logic [mcdl_pkg::FIELD_W-1:0]        pending_mask;

  modport source (output valid, output busy_res, output latched_events,
                  output pending_mask, input ready);
  modport sink   (input valid, input busy_res, input latched_events,
                  input pending_mask, output ready);
endinterface

[hw/rtl/mcdl_chan.sv]
// ----------------------------------------------------------------------------
// mcdl_chan
// One channel: low-run counter, pending mark and retrigger lockout timer.
// ----------------------------------------------------------------------------
module mcdl_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  mcdl_pkg::chan_cfg_t cfg,
  input  mcdl_pkg::chan_ctl_t ctl,
  output mcdl_pkg::chan_st_t  st
);

  logic [mcdl_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [mcdl_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic                         pend_r, pend_nxt;
  logic                         examine;
  logic [mcdl_pkg::COUNT_W:0]   run;
  logic                         trig;

  assign examine = !pend_r && (timer_r == '0);
  assign run     = {1'b0, count_r} + {{mcdl_pkg::COUNT_W{1'b0}}, 1'b1};
  assign trig    = examine && !ctl.level && (run >= {1'b0, cfg.debounce});

  always_comb begin
    count_nxt = count_r;
    if (examine) begin
      if (ctl.level || trig) begin
        count_nxt = '0;
      end else begin
        count_nxt = run[mcdl_pkg::COUNT_W-1:0];
      end
    end
  end

  // load then count down in the same tick
  always_comb begin
    if (trig) begin
      timer_nxt = (cfg.lockout == '0) ? '0 : cfg.lockout - 1'b1;
    end else if (timer_r != '0) begin
      timer_nxt = timer_r - 1'b1;
    end else begin
      timer_nxt = '0;
    end
  end

  assign pend_nxt = (pend_r || trig) && !ctl.absorb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      timer_r <= '0;
      pend_r  <= 1'b0;
    end else if (ctl.step) begin
      count_r <= count_nxt;
      timer_r <= timer_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign st.trig   = trig;
  assign st.pend   = pend_r || trig;
  assign st.pend_r = pend_r;

endmodule

[hw/rtl/multi_channel_debounce_lockout_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_debounce_lockout_top
// Debounces active-low sensor lines per channel, latches events, folds
// pending channels into one busy flag and holds off retriggers.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                  | handshake
//  --------+-----+-----------------------------------------+-------------
//  in_ch   | in  | pin_levels, clear_busy, clear_latched   | valid/ready
//  out_ch  | out | busy_res, latched_events, pending_mask  | valid/ready
//  cfg_*   | in  | cfg_idx, cfg_wdata                      | cfg_we only
//
//  one request per cycle while no result is stalled; its result shows in the cycle after it is taken
//  all channel state updates at the accepting edge, result goes to one
//  output register, so in_ch.ready = !out valid || out_ch.ready
//  a stalled result holds and blocks new requests only while it waits
//  synchronous active-low reset: counters, timers, flags cleared, settings
//  back to debounce 4 and lockout 200
//
module multi_channel_debounce_lockout_top #(
  parameter int unsigned CHANNELS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mcdl_in_if.sink                           in_ch,
  mcdl_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mcdl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mcdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned FW = mcdl_pkg::FIELD_W;

  // settings
  logic [mcdl_pkg::COUNT_W-1:0] debounce_r;
  logic [mcdl_pkg::TIMER_W-1:0] lockout_r;
  mcdl_pkg::chan_cfg_t          chan_cfg;

  // global flags
  logic                busy_r, busy_nxt, busy_eff;
  logic [CHANNELS-1:0] latched_r, latched_nxt;

  // per-channel vectors
  logic [CHANNELS-1:0] lvl_vec, clr_vec, trig_vec, pend_vec, pend_r_vec;
  logic [CHANNELS-1:0] pend_nxt_vec;
  logic                any_pend, absorb;

  // handshake
  logic in_ready, accept;
  logic out_valid_r;
  logic            busy_out_r;
  logic [FW-1:0]   latched_out_r, pend_out_r;
  logic [FW-1:0]   latched_field, pend_field;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= mcdl_pkg::DEBOUNCE_RST;
      lockout_r  <= mcdl_pkg::LOCKOUT_RST;
    end else if (cfg_we) begin
      case (mcdl_pkg::reg_idx_t'(cfg_idx))
        mcdl_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[mcdl_pkg::COUNT_W-1:0];
        mcdl_pkg::REG_LOCKOUT:  lockout_r  <= cfg_wdata[mcdl_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign chan_cfg.debounce = debounce_r;
  assign chan_cfg.lockout  = lockout_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // channels past the field width see a constant active level and no clear
  genvar gi;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_chan
      mcdl_pkg::chan_ctl_t ctl;
      mcdl_pkg::chan_st_t  st;

      if (gi < FW) begin : g_in
        assign lvl_vec[gi] = in_ch.pin_levels[gi];
        assign clr_vec[gi] = in_ch.clear_latched[gi];
      end else begin : g_zero
        assign lvl_vec[gi] = 1'b0;
        assign clr_vec[gi] = 1'b0;
      end

      assign ctl.step   = accept;
      assign ctl.level  = lvl_vec[gi];
      assign ctl.absorb = absorb;

      mcdl_chan u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (chan_cfg),
        .ctl   (ctl),
        .st    (st)
      );

      assign trig_vec[gi]     = st.trig;
      assign pend_vec[gi]     = st.pend;
      assign pend_r_vec[gi]   = st.pend_r;
      assign pend_nxt_vec[gi] = st.pend && !absorb;
    end

    // result fields keep the low bits only
    for (gi = 0; gi < FW; gi++) begin : g_field
      if (gi < CHANNELS) begin : g_live
        assign latched_field[gi] = latched_nxt[gi];
        assign pend_field[gi]    = pend_nxt_vec[gi];
      end else begin : g_pad
        assign latched_field[gi] = 1'b0;
        assign pend_field[gi]    = 1'b0;
      end
    end
  endgenerate

  // clears apply first, then triggers, then busy absorbs the pending set
  assign busy_eff    = busy_r && !in_ch.clear_busy;
  assign any_pend    = |pend_vec;
  assign absorb      = !busy_eff && any_pend;
  assign busy_nxt    = busy_eff || any_pend;
  assign latched_nxt = (latched_r & ~clr_vec) | trig_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      latched_r <= '0;
    end else if (accept) begin
      busy_r    <= busy_nxt;
      latched_r <= latched_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      busy_out_r    <= busy_nxt;
      latched_out_r <= latched_field;
      pend_out_r    <= pend_field;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.busy_res       = busy_out_r;
  assign out_ch.latched_events = latched_out_r;
  assign out_ch.pending_mask   = pend_out_r;

  // a waiting result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !accept)
    else $error("request taken while result stalled");

  // every taken request leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // a pending mark survives a tick only while busy is held
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|pend_r_vec) |-> busy_r)
    else $error("pending mark without busy");

  // result busy matches the stored flag right after a request
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_ch.busy_res == busy_r))
    else $error("result busy differs from flag");

endmodule
